FILE: hw/rtl/three_voice_square_tone_generator_unit_defines.svh
// assertion macros for the square tone generator checker
// depends on nothing; included by the checker file
`ifndef THREE_VOICE_SQUARE_TONE_GENERATOR_UNIT_DEFINES_SVH
`define THREE_VOICE_SQUARE_TONE_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define TVSTG_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define TVSTG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tvstg_pkg.sv
// shared types, constants and helpers of the square tone generator
// used by every rtl module of the block but the checker; depends on nothing
package tvstg_pkg;

  localparam int TICK_RATE_HZ = 1000000;
  localparam int MIN_FREQ_HZ  = 20;
  localparam int PCT_SCALE    = 100;
  localparam int MIN_TICKS    = 2;

  localparam int FREQ_W  = 16;
  localparam int VOL_W   = 7;
  localparam int LEN_W   = 16;
  localparam int LEN_CAP = 1 << LEN_W;
  localparam int DVD_W   = $clog2(TICK_RATE_HZ + 1);
  localparam int FULL_W  = $clog2(TICK_RATE_HZ / MIN_FREQ_HZ + 1);
  localparam int PROD_W  = FULL_W + VOL_W;
  localparam int RCP_S   = PROD_W + 7;
  localparam longint RCP_M = ((64'd1 << RCP_S) + 64'(PCT_SCALE - 1)) / 64'(PCT_SCALE);
  localparam int RCP_W   = $clog2(RCP_M + 1);
  localparam int MULT_W  = PROD_W + RCP_W;
  localparam int STEP_W  = $clog2(DVD_W);

  localparam logic [RCP_W-1:0]  RCP        = RCP_W'(RCP_M);
  localparam logic [FREQ_W-1:0] MIN_FREQ   = FREQ_W'(MIN_FREQ_HZ);
  localparam logic [VOL_W-1:0]  VOL_MAX    = VOL_W'(PCT_SCALE);
  localparam logic [VOL_W-1:0]  VOL_RESET  = VOL_W'(50);
  localparam logic [1:0]        VC_RESET   = 2'd3;

  localparam logic [1:0] CFG_VOLUME  = 2'd0;
  localparam logic [1:0] CFG_HARMONY = 2'd1;
  localparam logic [1:0] CFG_VOICES  = 2'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_NOTE  = 2'd1,
    OP_CHORD = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    HARM_OFF    = 2'd0,
    HARM_UNISON = 2'd1,
    HARM_OCTAVE = 2'd2,
    HARM_FIFTH  = 2'd3
  } harm_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SELECT,
    ST_DIV,
    ST_MUL_VOL,
    ST_MUL_RCP,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       tick;
    logic       stop_all;
    logic       div_start;
    logic       mul_vol;
    logic       mul_rcp;
    logic       write;
    logic       out_load;
    logic [1:0] voice;
  } cmd_t;

  typedef struct packed {
    op_t        op;
    logic       stop_first;
    logic [2:0] start_mask;
    logic       div_done;
  } status_t;

  // phase length in ticks, clamped to [2, 65536], stored minus one
  function automatic logic [LEN_W-1:0] len_m1(input logic [FULL_W-1:0] ticks);
    logic [FULL_W:0] t;
    t = {1'b0, ticks};
    if (t < (FULL_W+1)'(MIN_TICKS)) begin
      len_m1 = LEN_W'(MIN_TICKS - 1);
    end else if (t > (FULL_W+1)'(LEN_CAP)) begin
      len_m1 = '1;
    end else begin
      len_m1 = LEN_W'(t - (FULL_W+1)'(1));
    end
  endfunction

endpackage

FILE: hw/rtl/three_voice_square_tone_generator_unit.sv
// top level of the three voice square tone generator
// depends on tvstg_pkg, tvstg_ctrl, tvstg_dp (which holds tvstg_div)
//
// Usage:
//   input channel (in_valid / in_stall) carries one command per beat:
//   a 1 us tick, a single note on freq_a, a chord on freq_a..c, or stop all.
//   every command yields exactly one result beat on the out channel with the
//   three active-low pin levels and the running-voice mask after the update.
//   cfg channel (cfg_valid / cfg_ready, always ready) writes volume, harmony
//   and chord voice count; write only while no command is in flight.
// Sequencing:
//   tick, stop, and a rest go from dispatch straight to finish.
//   each voice started adds a pass through the shared 20-step
//   radix-2 period divider followed by two registered multiplies.
//   one command is in work at a time; the next is taken in the cycle after
//   the result is loaded.
// Reset: synchronous active-low rst_n; all lane pins high, no voice running,
//   volume 50, harmony off, voice count 3; the result beat register is not reset.
// Stall: while out_stall holds, the result beat stays unchanged and a
//   finished command waits before the next is taken.
module three_voice_square_tone_generator_unit #(
  parameter int VOICE_COUNT = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_operation,
  input  logic [tvstg_pkg::FREQ_W-1:0]     in_freq_a,
  input  logic [tvstg_pkg::FREQ_W-1:0]     in_freq_b,
  input  logic [tvstg_pkg::FREQ_W-1:0]     in_freq_c,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pin_level_0,
  output logic                             out_pin_level_1,
  output logic                             out_pin_level_2,
  output logic [2:0]                       out_active_mask,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [tvstg_pkg::VOL_W-1:0]      cfg_data
);

  tvstg_pkg::cmd_t    cmd;
  tvstg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tvstg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tvstg_dp #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_operation    (in_operation),
    .in_freq_a       (in_freq_a),
    .in_freq_b       (in_freq_b),
    .in_freq_c       (in_freq_c),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_pin_level_0 (out_pin_level_0),
    .out_pin_level_1 (out_pin_level_1),
    .out_pin_level_2 (out_pin_level_2),
    .out_active_mask (out_active_mask)
  );

endmodule

FILE: hw/rtl/tvstg_div.sv
// radix-2 restoring divider: tick rate divided by a frequency, one bit a cycle
// depends on tvstg_pkg
module tvstg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tvstg_pkg::FREQ_W-1:0]   divisor,
  output logic                           done,
  output logic [tvstg_pkg::FULL_W-1:0]   quotient
);

  localparam int DW = tvstg_pkg::DVD_W;
  localparam int FW = tvstg_pkg::FREQ_W;
  localparam logic [DW-1:0] DIVIDEND = DW'(tvstg_pkg::TICK_RATE_HZ);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [tvstg_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [FW-1:0]                      rem_r, rem_nxt;
  logic [DW-1:0]                      quo_r, quo_nxt;
  logic [FW-1:0]                      dvs_r;
  logic [FW:0]                        trial;
  logic [FW:0]                        diff;
  logic                               fits;
  logic                               last;

  assign trial = {rem_r, quo_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});
  assign last  = (step_r == tvstg_pkg::STEP_W'(DW - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = DIVIDEND;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[FW-1:0] : trial[FW-1:0];
      quo_nxt  = {quo_r[DW-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[tvstg_pkg::FULL_W-1:0];

endmodule

FILE: hw/rtl/tvstg_ctrl.sv
// controller state machine: sequences tick, stop and voice start work
// depends on tvstg_pkg; drives the datapath through cmd_t
module tvstg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  tvstg_pkg::status_t  status,
  output tvstg_pkg::cmd_t     cmd
);

  tvstg_pkg::state_t state_r, state_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic [1:0]        voice_r, voice_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        pick;
  logic [2:0]        voice_bit;
  logic              out_free;

  always_comb begin
    priority if (pend_r[0]) begin
      pick = 2'd0;
    end else if (pend_r[1]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
  end

  assign voice_bit = 3'b001 << voice_r;
  assign out_free  = !(out_valid_r && out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    voice_nxt = voice_r;
    unique case (state_r)
      tvstg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tvstg_pkg::ST_DISPATCH;
      end
      tvstg_pkg::ST_DISPATCH: begin
        pend_nxt = status.start_mask;
        if (status.op == tvstg_pkg::OP_TICK || status.start_mask == 3'b000) begin
          state_nxt = tvstg_pkg::ST_FINISH;
        end else begin
          state_nxt = tvstg_pkg::ST_SELECT;
        end
      end
      tvstg_pkg::ST_SELECT: begin
        voice_nxt = pick;
        state_nxt = tvstg_pkg::ST_DIV;
      end
      tvstg_pkg::ST_DIV: begin
        if (status.div_done) state_nxt = tvstg_pkg::ST_MUL_VOL;
      end
      tvstg_pkg::ST_MUL_VOL: begin
        state_nxt = tvstg_pkg::ST_MUL_RCP;
      end
      tvstg_pkg::ST_MUL_RCP: begin
        state_nxt = tvstg_pkg::ST_WRITE;
      end
      tvstg_pkg::ST_WRITE: begin
        pend_nxt = pend_r & ~voice_bit;
        if ((pend_r & ~voice_bit) != 3'b000) begin
          state_nxt = tvstg_pkg::ST_SELECT;
        end else begin
          state_nxt = tvstg_pkg::ST_FINISH;
        end
      end
      tvstg_pkg::ST_FINISH: begin
        if (out_free) state_nxt = tvstg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tvstg_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.voice = voice_r;
    unique case (state_r)
      tvstg_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      tvstg_pkg::ST_DISPATCH: begin
        cmd.tick     = (status.op == tvstg_pkg::OP_TICK);
        cmd.stop_all = status.stop_first;
      end
      tvstg_pkg::ST_SELECT: begin
        cmd.voice     = pick;
        cmd.div_start = 1'b1;
      end
      tvstg_pkg::ST_MUL_VOL: begin
        cmd.mul_vol = 1'b1;
      end
      tvstg_pkg::ST_MUL_RCP: begin
        cmd.mul_rcp = 1'b1;
      end
      tvstg_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
      end
      tvstg_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvstg_pkg::ST_IDLE;
      pend_r      <= '0;
      voice_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      voice_r     <= voice_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != tvstg_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/tvstg_dp.sv
// datapath: config registers, voice lanes, period and duty arithmetic, result register
// depends on tvstg_pkg and tvstg_div; steered by tvstg_ctrl through cmd_t
module tvstg_dp #(
  parameter int VOICE_COUNT = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tvstg_pkg::cmd_t                    cmd,
  output tvstg_pkg::status_t                 status,
  input  logic [1:0]                         in_operation,
  input  logic [tvstg_pkg::FREQ_W-1:0]       in_freq_a,
  input  logic [tvstg_pkg::FREQ_W-1:0]       in_freq_b,
  input  logic [tvstg_pkg::FREQ_W-1:0]       in_freq_c,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [tvstg_pkg::VOL_W-1:0]        cfg_data,
  output logic                               out_pin_level_0,
  output logic                               out_pin_level_1,
  output logic                               out_pin_level_2,
  output logic [2:0]                         out_active_mask
);

  localparam int FW = tvstg_pkg::FREQ_W;
  localparam int LW = tvstg_pkg::LEN_W;

  logic [tvstg_pkg::VOL_W-1:0]  vol_r;
  tvstg_pkg::harm_t             harm_r;
  logic [1:0]                   vc_r;

  tvstg_pkg::op_t               op_r;
  logic [FW-1:0]                fa_r, fb_r, fc_r;

  logic [FW+1:0]                f3;
  logic [FW-1:0]                hf;
  logic                         harm_ok;
  logic [2:0]                   freq_ok;
  logic [2:0]                   lane_ok;
  logic [2:0]                   chord_mask;
  logic [FW-1:0]                divisor;
  logic                         div_done;
  logic [tvstg_pkg::FULL_W-1:0] full;

  logic [tvstg_pkg::PROD_W-1:0] p_r;
  logic [tvstg_pkg::MULT_W-1:0] prod_r;
  logic [tvstg_pkg::FULL_W-1:0] lo_ticks, hi_ticks;
  logic [LW-1:0]                llen, hlen;

  logic [LW-1:0]                cnt_r  [VOICE_COUNT];
  logic [LW-1:0]                hlen_r [VOICE_COUNT];
  logic [LW-1:0]                llen_r [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]       high_r, run_r, pin_r;
  logic [2:0]                   pins_vis, run_vis;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r  <= tvstg_pkg::VOL_RESET;
      harm_r <= tvstg_pkg::HARM_OFF;
      vc_r   <= tvstg_pkg::VC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvstg_pkg::CFG_VOLUME: begin
          if (cfg_data <= tvstg_pkg::VOL_MAX) vol_r <= cfg_data;
        end
        tvstg_pkg::CFG_HARMONY: begin
          harm_r <= tvstg_pkg::harm_t'(cfg_data[1:0]);
        end
        tvstg_pkg::CFG_VOICES: begin
          vc_r <= cfg_data[1:0];
        end
        default: begin
          vc_r <= vc_r;
        end
      endcase
    end
  end

  // input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= tvstg_pkg::op_t'(in_operation);
      fa_r <= in_freq_a;
      fb_r <= in_freq_b;
      fc_r <= in_freq_c;
    end
  end

  // harmony frequency, truncated to 16 bits
  assign f3 = {2'b00, fa_r} + {1'b0, fa_r, 1'b0};

  always_comb begin
    unique case (harm_r)
      tvstg_pkg::HARM_OCTAVE: hf = {fa_r[FW-2:0], 1'b0};
      tvstg_pkg::HARM_FIFTH:  hf = f3[FW:1];
      default:                hf = fa_r;
    endcase
  end

  assign harm_ok = (harm_r != tvstg_pkg::HARM_OFF) && (VOICE_COUNT >= 2)
                   && (hf >= tvstg_pkg::MIN_FREQ);

  assign freq_ok[0] = (fa_r >= tvstg_pkg::MIN_FREQ);
  assign freq_ok[1] = (fb_r >= tvstg_pkg::MIN_FREQ);
  assign freq_ok[2] = (fc_r >= tvstg_pkg::MIN_FREQ);

  for (genvar k = 0; k < 3; k++) begin : g_ok
    assign lane_ok[k]    = (VOICE_COUNT > k);
    assign chord_mask[k] = freq_ok[k] && lane_ok[k] && (vc_r > 2'(k));
  end

  always_comb begin
    status.op         = op_r;
    status.div_done   = div_done;
    status.stop_first = 1'b0;
    status.start_mask = 3'b000;
    unique case (op_r)
      tvstg_pkg::OP_TICK: begin
        status.stop_first = 1'b0;
      end
      tvstg_pkg::OP_NOTE: begin
        if (!freq_ok[0]) begin
          status.stop_first = 1'b1;
        end else begin
          status.start_mask = {1'b0, harm_ok, 1'b1};
        end
      end
      tvstg_pkg::OP_CHORD: begin
        status.stop_first = 1'b1;
        status.start_mask = chord_mask;
      end
      tvstg_pkg::OP_STOP: begin
        status.stop_first = 1'b1;
      end
      default: begin
        status.stop_first = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.voice)
      2'd0:    divisor = fa_r;
      2'd1:    divisor = (op_r == tvstg_pkg::OP_NOTE) ? hf : fb_r;
      default: divisor = fc_r;
    endcase
  end

  tvstg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (full)
  );

  // low share = full * volume / 100 via reciprocal multiply
  always_ff @(posedge clk) begin
    if (cmd.mul_vol) begin
      p_r <= tvstg_pkg::PROD_W'(full) * tvstg_pkg::PROD_W'(vol_r);
    end
    if (cmd.mul_rcp) begin
      prod_r <= tvstg_pkg::MULT_W'(p_r) * tvstg_pkg::MULT_W'(tvstg_pkg::RCP);
    end
  end

  assign lo_ticks = prod_r[tvstg_pkg::RCP_S +: tvstg_pkg::FULL_W];
  assign hi_ticks = full - lo_ticks;
  assign llen     = tvstg_pkg::len_m1(lo_ticks);
  assign hlen     = tvstg_pkg::len_m1(hi_ticks);

  // voice lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        cnt_r[v]  <= '0;
        hlen_r[v] <= '0;
        llen_r[v] <= '0;
        high_r[v] <= 1'b1;
        run_r[v]  <= 1'b0;
        pin_r[v]  <= 1'b1;
      end
    end else begin
      for (int v = 0; v < VOICE_COUNT; v++) begin
        if (cmd.tick) begin
          if (run_r[v]) begin
            if (cnt_r[v] >= (high_r[v] ? hlen_r[v] : llen_r[v])) begin
              cnt_r[v]  <= '0;
              high_r[v] <= !high_r[v];
              pin_r[v]  <= !high_r[v];
            end else begin
              cnt_r[v] <= cnt_r[v] + 1'b1;
            end
          end
        end else if (cmd.stop_all) begin
          run_r[v] <= 1'b0;
          pin_r[v] <= 1'b1;
        end else if (cmd.write && (32'(cmd.voice) == v)) begin
          hlen_r[v] <= hlen;
          llen_r[v] <= llen;
          cnt_r[v]  <= '0;
          high_r[v] <= 1'b1;
          run_r[v]  <= 1'b1;
          pin_r[v]  <= 1'b1;
        end
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_vis
    if (k < VOICE_COUNT) begin : g_lane
      assign pins_vis[k] = pin_r[k];
      assign run_vis[k]  = run_r[k];
    end else begin : g_none
      assign pins_vis[k] = 1'b1;
      assign run_vis[k]  = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pin_level_0 <= pins_vis[0];
      out_pin_level_1 <= pins_vis[1];
      out_pin_level_2 <= pins_vis[2];
      out_active_mask <= run_vis;
    end
  end

endmodule

FILE: hw/rtl/tvstg_chk.sv
// port-level checker for the square tone generator, bound to the top level
// depends on three_voice_square_tone_generator_unit_defines.svh
`include "three_voice_square_tone_generator_unit_defines.svh"

module tvstg_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_pin_level_0,
  input logic       out_pin_level_1,
  input logic       out_pin_level_2,
  input logic [2:0] out_active_mask
);

  // a stalled result beat holds
  `TVSTG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_active_mask) && $stable(out_pin_level_0) && $stable(out_pin_level_1) && $stable(out_pin_level_2), "stalled result beat changed")

  // one command in work at a time
  `TVSTG_ASSERT_NEXT(a_one_cmd, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while a command is in work")

  // an idle voice keeps its pin high
  `TVSTG_ASSERT_NOW(a_idle_pin, clk, rst_n, out_valid, (out_active_mask[0] || out_pin_level_0) && (out_active_mask[1] || out_pin_level_1) && (out_active_mask[2] || out_pin_level_2), "stopped voice drives its pin low")

endmodule

bind three_voice_square_tone_generator_unit tvstg_chk u_tvstg_chk (.*);

FILE: tb/sv/tb_top.sv
// self-checking testbench for three_voice_square_tone_generator_unit
// a directed table and random phases run against a voice-state predictor
// depends on tvstg_pkg and the rtl of the tone generator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int CFG_GAP = 10;
  localparam int END_GAP = 100;

  typedef struct packed {
    logic [2:0] pins;
    logic [2:0] mask;
  } tone_beat_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    tvstg_pkg::op_t    op;
    logic [15:0]       fa;
    logic [15:0]       fb;
    logic [15:0]       fc;
    logic              known;
    tone_beat_t        beat;
    logic [1:0]        idx;
    logic [6:0]        val;
  } plan_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [1:0]                  in_operation;
  logic [15:0]                 in_freq_a;
  logic [15:0]                 in_freq_b;
  logic [15:0]                 in_freq_c;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_pin_level_0;
  logic                        out_pin_level_1;
  logic                        out_pin_level_2;
  logic [2:0]                  out_active_mask;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index;
  logic [tvstg_pkg::VOL_W-1:0] cfg_data;

  // voice state and settings as the block should hold them
  logic [15:0]       ph_cnt [3];
  logic [15:0]       hi_len [3];
  logic [15:0]       lo_len [3];
  logic              in_hi [3];
  logic              running [3];
  logic              pin [3];
  logic [6:0]        vol_pct;
  tvstg_pkg::harm_t  harm_sel;
  logic [1:0]        voices_allowed;

  tone_beat_t  pin_q [$];
  plan_row_t   plan [$];
  int          err_count;
  int          hold_req;
  bit          idle_en;

  three_voice_square_tone_generator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_freq_a       (in_freq_a),
    .in_freq_b       (in_freq_b),
    .in_freq_c       (in_freq_c),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pin_level_0 (out_pin_level_0),
    .out_pin_level_1 (out_pin_level_1),
    .out_pin_level_2 (out_pin_level_2),
    .out_active_mask (out_active_mask),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [15:0] phase_len(int unsigned ticks);
    if (ticks < 2) ticks = 2;
    if (ticks > 65536) ticks = 65536;
    return 16'(ticks - 1);
  endfunction

  function automatic void voice_off(int v);
    running[v] = 1'b0;
    pin[v] = 1'b1;
  endfunction

  function automatic void voice_on(int v, int unsigned f);
    int unsigned full;
    int unsigned lo;
    if (f < tvstg_pkg::MIN_FREQ_HZ) begin
      voice_off(v);
      return;
    end
    full = tvstg_pkg::TICK_RATE_HZ / f;
    lo = (full * vol_pct) / 100;
    lo_len[v] = phase_len(lo);
    hi_len[v] = phase_len(full - lo);
    in_hi[v] = 1'b1;
    ph_cnt[v] = '0;
    running[v] = 1'b1;
    pin[v] = 1'b1;
  endfunction

  function automatic void tone_reset();
    vol_pct = 7'd50;
    harm_sel = tvstg_pkg::HARM_OFF;
    voices_allowed = 2'd3;
    for (int v = 0; v < 3; v++) begin
      ph_cnt[v] = '0;
      hi_len[v] = '0;
      lo_len[v] = '0;
      in_hi[v] = 1'b1;
      running[v] = 1'b0;
      pin[v] = 1'b1;
    end
  endfunction

  function automatic void tone_config(logic [1:0] idx, logic [6:0] val);
    case (idx)
      tvstg_pkg::CFG_VOLUME: begin
        if (val <= 7'd100) vol_pct = val;
      end
      tvstg_pkg::CFG_HARMONY: harm_sel = tvstg_pkg::harm_t'(val[1:0]);
      tvstg_pkg::CFG_VOICES: voices_allowed = val[1:0];
      default: ;
    endcase
  endfunction

  function automatic tone_beat_t tone_predict(tvstg_pkg::op_t op, logic [15:0] fa,
                                              logic [15:0] fb, logic [15:0] fc);
    tone_beat_t  res;
    logic [15:0] hf;
    logic [15:0] fr [3];
    logic [15:0] limit;
    fr[0] = fa;
    fr[1] = fb;
    fr[2] = fc;
    case (op)
      tvstg_pkg::OP_TICK: begin
        for (int v = 0; v < 3; v++) begin
          if (running[v]) begin
            limit = in_hi[v] ? hi_len[v] : lo_len[v];
            if (ph_cnt[v] >= limit) begin
              ph_cnt[v] = '0;
              in_hi[v] = ~in_hi[v];
              pin[v] = ~pin[v];
            end else begin
              ph_cnt[v] = ph_cnt[v] + 16'd1;
            end
          end
        end
      end
      tvstg_pkg::OP_NOTE: begin
        if (fa < tvstg_pkg::MIN_FREQ_HZ) begin
          for (int v = 0; v < 3; v++) voice_off(v);
        end else begin
          voice_on(0, fa);
          if (harm_sel != tvstg_pkg::HARM_OFF) begin
            case (harm_sel)
              tvstg_pkg::HARM_UNISON: hf = fa;
              tvstg_pkg::HARM_OCTAVE: hf = 16'(32'(fa) * 2);
              default: hf = 16'((32'(fa) * 3) / 2);
            endcase
            if (hf >= tvstg_pkg::MIN_FREQ_HZ) voice_on(1, hf);
          end
        end
      end
      tvstg_pkg::OP_CHORD: begin
        for (int v = 0; v < 3; v++) voice_off(v);
        for (int v = 0; v < 3; v++) begin
          if (v < voices_allowed && fr[v] >= tvstg_pkg::MIN_FREQ_HZ) voice_on(v, fr[v]);
        end
      end
      default: begin
        for (int v = 0; v < 3; v++) voice_off(v);
      end
    endcase
    for (int v = 0; v < 3; v++) begin
      res.pins[v] = pin[v];
      res.mask[v] = running[v];
    end
    return res;
  endfunction

  function automatic void row_beat(tvstg_pkg::op_t op, logic [15:0] fa, logic [15:0] fb,
                                   logic [15:0] fc);
    plan_row_t r;
    r.kind = ROW_BEAT;
    r.op = op;
    r.fa = fa;
    r.fb = fb;
    r.fc = fc;
    r.known = 1'b0;
    r.beat = '0;
    r.idx = '0;
    r.val = '0;
    plan.push_back(r);
  endfunction

  function automatic void row_known(tvstg_pkg::op_t op, logic [15:0] fa, logic [15:0] fb,
                                    logic [15:0] fc, logic [2:0] pins, logic [2:0] mask);
    row_beat(op, fa, fb, fc);
    plan[$].known = 1'b1;
    plan[$].beat = '{pins: pins, mask: mask};
  endfunction

  function automatic void row_cfg(logic [1:0] idx, logic [6:0] val);
    row_beat(tvstg_pkg::OP_TICK, '0, '0, '0);
    plan[$].kind = ROW_CFG;
    plan[$].idx = idx;
    plan[$].val = val;
  endfunction

  function automatic logic [15:0] rand_freq();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 19));
      1: return 16'($urandom);
      2: return 16'($urandom_range(20, 2000));
      default: return 16'($urandom_range(8000, 65535));
    endcase
  endfunction

  task automatic send(tvstg_pkg::op_t op, logic [15:0] fa, logic [15:0] fb,
                      logic [15:0] fc, logic known, tone_beat_t beat);
    tone_beat_t pred;
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_freq_a <= fa;
    in_freq_b <= fb;
    in_freq_c <= fc;
    do @(posedge clk); while (in_stall);
    pred = tone_predict(op, fa, fb, fc);
    pin_q.push_back(known ? beat : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_q.size() != 0) @(posedge clk);
    repeat (CFG_GAP) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tone_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result monitor
  always @(posedge clk) begin
    tone_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pin_q.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        exp_beat = pin_q.pop_front();
        if (out_pin_level_0 !== exp_beat.pins[0]) begin
          $error("pin_level_0 expected %0b got %0b", exp_beat.pins[0], out_pin_level_0);
          err_count++;
        end
        if (out_pin_level_1 !== exp_beat.pins[1]) begin
          $error("pin_level_1 expected %0b got %0b", exp_beat.pins[1], out_pin_level_1);
          err_count++;
        end
        if (out_pin_level_2 !== exp_beat.pins[2]) begin
          $error("pin_level_2 expected %0b got %0b", exp_beat.pins[2], out_pin_level_2);
          err_count++;
        end
        if (out_active_mask !== exp_beat.mask) begin
          $error("active_mask expected %03b got %03b", exp_beat.mask, out_active_mask);
          err_count++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_en && ($urandom_range(0, 99) < 28);
      end
    end
  end

  initial begin
    tvstg_pkg::op_t op;
    int             r;
    logic [6:0]     vol_val;
    logic [6:0]     vc_val;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = tvstg_pkg::OP_TICK;
    in_freq_a = '0;
    in_freq_b = '0;
    in_freq_c = '0;
    cfg_valid = 1'b0;
    cfg_index = tvstg_pkg::CFG_VOLUME;
    cfg_data = '0;
    err_count = 0;
    hold_req = 0;
    idle_en = 1'b1;
    tone_reset();

    row_known(tvstg_pkg::OP_TICK, 16'd0, 16'd0, 16'd0, 3'b111, 3'b000);
    row_known(tvstg_pkg::OP_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 3'b000);
    row_known(tvstg_pkg::OP_NOTE, 16'd0, 16'hFFFF, 16'hFFFF, 3'b111, 3'b000);
    row_known(tvstg_pkg::OP_NOTE, 16'd20, 16'd0, 16'd0, 3'b111, 3'b001);
    row_known(tvstg_pkg::OP_CHORD, 16'hFFFF, 16'd20, 16'd19, 3'b111, 3'b011);
    row_known(tvstg_pkg::OP_CHORD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 3'b111);
    row_beat(tvstg_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    row_known(tvstg_pkg::OP_STOP, 16'd0, 16'd0, 16'd0, 3'b111, 3'b000);
    row_known(tvstg_pkg::OP_NOTE, 16'hFFFF, 16'd0, 16'd0, 3'b111, 3'b001);
    repeat (8) row_beat(tvstg_pkg::OP_TICK, 16'd0, 16'd0, 16'd0);
    // octave wraps to zero, voice 1 untouched
    row_cfg(tvstg_pkg::CFG_HARMONY, 7'(tvstg_pkg::HARM_OCTAVE));
    row_beat(tvstg_pkg::OP_NOTE, 16'd32768, 16'd0, 16'd0);
    row_known(tvstg_pkg::OP_NOTE, 16'd40000, 16'd0, 16'd0, 3'b111, 3'b011);
    row_cfg(tvstg_pkg::CFG_HARMONY, 7'(tvstg_pkg::HARM_FIFTH));
    row_known(tvstg_pkg::OP_NOTE, 16'hFFFF, 16'd0, 16'd0, 3'b111, 3'b011);
    row_known(tvstg_pkg::OP_NOTE, 16'd13, 16'd0, 16'd0, 3'b111, 3'b000);
    row_cfg(tvstg_pkg::CFG_VOICES, 7'd0);
    row_known(tvstg_pkg::OP_CHORD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 3'b000);
    row_cfg(tvstg_pkg::CFG_VOICES, 7'd1);
    row_known(tvstg_pkg::OP_CHORD, 16'd1000, 16'd1000, 16'd1000, 3'b111, 3'b001);
    row_cfg(tvstg_pkg::CFG_VOLUME, 7'd100);
    row_beat(tvstg_pkg::OP_NOTE, 16'hFFFF, 16'd0, 16'd0);
    // volume above 100 is dropped, unused index does nothing
    row_cfg(tvstg_pkg::CFG_VOLUME, 7'd0);
    row_cfg(tvstg_pkg::CFG_VOLUME, 7'd127);
    row_cfg(CFG_UNUSED, 7'h7F);
    row_beat(tvstg_pkg::OP_NOTE, 16'hFFFF, 16'd0, 16'd0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        send(plan[i].op, plan[i].fa, plan[i].fb, plan[i].fc, plan[i].known, plan[i].beat);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      idle_en = 1'b1;
      if (ph == 0) vol_val = 7'd0;
      else if (ph == 1) vol_val = 7'd100;
      else if ($urandom_range(0, 3) == 0) vol_val = 7'($urandom_range(101, 127));
      else vol_val = 7'($urandom_range(0, 100));
      if (ph == 0) vc_val = 7'd3;
      else if (ph == 1) vc_val = 7'd1;
      else vc_val = 7'($urandom_range(0, 127));
      cfg_write(tvstg_pkg::CFG_VOLUME, vol_val);
      cfg_write(tvstg_pkg::CFG_HARMONY, 7'($urandom_range(0, 127)));
      cfg_write(tvstg_pkg::CFG_VOICES, vc_val);
      if ($urandom_range(0, 1) == 1) cfg_write(CFG_UNUSED, 7'($urandom_range(0, 127)));
      if (ph == 1) idle_en = 1'b0;
      if (ph == 2) hold_req = 400;
      repeat (100) begin
        r = $urandom_range(0, 99);
        if (r < 55) op = tvstg_pkg::OP_TICK;
        else if (r < 72) op = tvstg_pkg::OP_NOTE;
        else if (r < 90) op = tvstg_pkg::OP_CHORD;
        else op = tvstg_pkg::OP_STOP;
        send(op, rand_freq(), rand_freq(), rand_freq(), 1'b0, '0);
      end
    end

    drain();
    repeat (END_GAP) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tvstg_pkg.sv
hw/rtl/tvstg_div.sv
hw/rtl/tvstg_ctrl.sv
hw/rtl/tvstg_dp.sv
hw/rtl/three_voice_square_tone_generator_unit.sv
hw/rtl/tvstg_chk.sv
tb/sv/tb_top.sv
